// ----- hw/rtl/vcfr_pkg.sv -----
`default_nettype none

package vcfr_pkg;

  localparam int unsigned FrameMaxLenDef = 16;
  localparam int unsigned LenWidth       = 5;

  localparam logic [7:0] HdrMask    = 8'hF0;
  localparam logic [7:0] HdrMark    = 8'h80;
  localparam logic [7:0] Terminator = 8'hFF;
  localparam logic [3:0] BroadcastAddr = 4'h8;
  localparam logic [3:0] DevAddrReset  = 4'h1;

  localparam logic [7:0] CmdZoom  = 8'h07;
  localparam logic [7:0] CmdFocus = 8'h08;
  localparam logic [7:0] ArgStop  = 8'h00;
  localparam logic [7:0] ArgUp    = 8'h02;
  localparam logic [7:0] ArgDown  = 8'h03;
  localparam logic [3:0] ZoomTeleHi = 4'h2;
  localparam logic [3:0] ZoomWideHi = 4'h3;

  typedef enum logic [2:0] {
    ActZoomTele  = 3'd0,
    ActZoomWide  = 3'd1,
    ActZoomStop  = 3'd2,
    ActFocusFar  = 3'd3,
    ActFocusNear = 3'd4,
    ActFocusStop = 3'd5,
    ActUnknown   = 3'd6,
    ActMismatch  = 3'd7
  } action_e;

  // one closed frame, handed from framer to decoder
  typedef struct packed {
    logic [3:0]          addr;
    logic [7:0]          cmd;
    logic [7:0]          arg;
    logic [LenWidth-1:0] len;
    logic                ovf;
  } frame_rec_t;

  function automatic action_e decode_action(input logic [3:0] addr,
                                            input logic [7:0] cmd,
                                            input logic [7:0] arg,
                                            input logic [3:0] dev_addr);
    action_e act;
    act = ActUnknown;
    if (addr != dev_addr && addr != BroadcastAddr) begin
      act = ActMismatch;
    end else if (cmd == CmdZoom) begin
      if (arg == ArgUp || arg[7:4] == ZoomTeleHi) begin
        act = ActZoomTele;
      end else if (arg == ArgDown || arg[7:4] == ZoomWideHi) begin
        act = ActZoomWide;
      end else if (arg == ArgStop) begin
        act = ActZoomStop;
      end
    end else if (cmd == CmdFocus) begin
      case (arg)
        ArgUp:   act = ActFocusFar;
        ArgDown: act = ActFocusNear;
        ArgStop: act = ActFocusStop;
        default: act = ActUnknown;
      endcase
    end
    return act;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vcfr_if.sv -----
`default_nettype none

interface vcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface vcfr_act_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       ended_by_overflow;
  logic [4:0] frame_length;
  modport source (output valid, output action, output ended_by_overflow,
                  output frame_length, input ready);
  modport sink (input valid, input action, input ended_by_overflow,
                input frame_length, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/visca_command_frame_receiver.sv -----
// channel | dir | handshake   | payload
// rx_i    | in  | valid/ready | rx_byte[7:0]
// act_o   | out | valid/ready | action[2:0], ended_by_overflow, frame_length[4:0]
// cfg     | in  | cfg_we_i    | cfg_wdata_i[3:0] (device address)
//
// one byte accepted per cycle while rx_i ready is high; a closing byte's item is registered
// first in the framer record register, then in the decoder output register
// rst_ni clears frame position, captured bytes and valids; device address resets to 1
// a stalled output holds one item in each of the two registers before rx_i drops ready
`default_nettype none

module visca_command_frame_receiver
  import vcfr_pkg::*;
#(
  parameter int unsigned FrameMaxLen = FrameMaxLenDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  vcfr_rx_if.sink         rx_i,
  vcfr_act_if.source      act_o
);

  frame_rec_t rec;
  logic       rec_valid, rec_ready;

  vcfr_framer #(
    .FrameMaxLen(FrameMaxLen)
  ) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx         (rx_i),
    .rec_o      (rec),
    .rec_valid_o(rec_valid),
    .rec_ready_i(rec_ready)
  );

  vcfr_decoder u_decoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rec_i      (rec),
    .rec_valid_i(rec_valid),
    .rec_ready_o(rec_ready),
    .act        (act_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/vcfr_framer.sv -----
`default_nettype none

module vcfr_framer
  import vcfr_pkg::*;
#(
  parameter int unsigned FrameMaxLen = FrameMaxLenDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  vcfr_rx_if.sink       rx,
  output frame_rec_t    rec_o,
  output logic          rec_valid_o,
  input  wire logic     rec_ready_i
);

  logic [LenWidth-1:0] count_q, count_d, count_base, len;
  logic [7:0]          hdr_q, hdr_d, cmd_q, cmd_d, arg_q, arg_d;
  logic                is_hdr, term, close, accept;
  logic                rec_valid_q;
  frame_rec_t          rec_q;

  assign rx.ready = !rec_valid_q || rec_ready_i;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    is_hdr     = (rx.rx_byte & HdrMask) == HdrMark;
    count_base = is_hdr ? '0 : count_q;
    hdr_d      = hdr_q;
    cmd_d      = cmd_q;
    arg_d      = arg_q;
    case (count_base)
      LenWidth'(0): hdr_d = rx.rx_byte;
      LenWidth'(3): cmd_d = rx.rx_byte;
      LenWidth'(4): arg_d = rx.rx_byte;
      default: ;
    endcase
    // count_base stays below FrameMaxLen, so len never wraps
    len     = count_base + LenWidth'(1);
    term    = rx.rx_byte == Terminator;
    close   = term || (len >= LenWidth'(FrameMaxLen));
    count_d = close ? '0 : len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      hdr_q       <= '0;
      cmd_q       <= '0;
      arg_q       <= '0;
      rec_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
        hdr_q   <= hdr_d;
        cmd_q   <= cmd_d;
        arg_q   <= arg_d;
      end
      if (rx.ready) begin
        rec_valid_q <= accept && close;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && close) begin
      rec_q.addr <= hdr_d[3:0];
      rec_q.cmd  <= cmd_d;
      rec_q.arg  <= arg_d;
      rec_q.len  <= len;
      rec_q.ovf  <= !term;
    end
  end

  assign rec_o       = rec_q;
  assign rec_valid_o = rec_valid_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < LenWidth'(FrameMaxLen))
    else $error("frame position reached the buffer length");

  a_ovf_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_q && rec_q.ovf |-> rec_q.len == LenWidth'(FrameMaxLen))
    else $error("overflow close with short length");

  a_term_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rx.rx_byte == Terminator |=> rec_valid_q && !rec_q.ovf && count_q == '0)
    else $error("terminator did not close the frame");

endmodule

`default_nettype wire

// ----- hw/rtl/vcfr_decoder.sv -----
`default_nettype none

module vcfr_decoder
  import vcfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  input  wire frame_rec_t rec_i,
  input  wire logic       rec_valid_i,
  output logic            rec_ready_o,
  vcfr_act_if.source      act
);

  logic [3:0]          dev_addr_q;
  logic                out_valid_q;
  action_e             action_q;
  logic                ovf_q;
  logic [LenWidth-1:0] len_q;
  logic                take;

  assign rec_ready_o = !out_valid_q || act.ready;
  assign take        = rec_valid_i && rec_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DevAddrReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dev_addr_q <= cfg_wdata_i;
      end
      if (rec_ready_o) begin
        out_valid_q <= rec_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      action_q <= decode_action(rec_i.addr, rec_i.cmd, rec_i.arg, dev_addr_q);
      ovf_q    <= rec_i.ovf;
      len_q    <= rec_i.len;
    end
  end

  assign act.valid             = out_valid_q;
  assign act.action            = action_q;
  assign act.ended_by_overflow = ovf_q;
  assign act.frame_length      = len_q;

  a_take_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_q)
    else $error("decoded item lost");

  a_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> len_q != '0)
    else $error("zero-length frame reported");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;
  import vcfr_pkg::*;

  localparam int FrameLen  = FrameMaxLenDef;
  localparam int PhaseLen  = 160;
  localparam int HoldLen   = 80;
  localparam int Watchdog  = 2000;
  localparam int DrainWait = 4;

  typedef struct packed {
    action_e    action;
    logic       ended_by_overflow;
    logic [4:0] frame_length;
  } act_rec_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       typed;
    act_rec_t   want;
  } stim_row_t;

  localparam act_rec_t NoRes = '{ActUnknown, 1'b0, 5'd0};

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  vcfr_rx_if  rx_if ();
  vcfr_act_if act_if ();

  visca_command_frame_receiver #(
    .FrameMaxLen(FrameLen)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .rx_i       (rx_if),
    .act_o      (act_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the framer state and the address register
  logic [4:0] frame_pos;
  logic [7:0] hdr_cap, cmd_cap, arg_cap;
  logic [3:0] dev_addr;

  act_rec_t pending_actions[$];
  act_rec_t want;
  int       errors = 0;
  int       bytes_sent = 0;
  int       quiet = 0;
  bit       calm = 1'b0;
  int       holds_asked = 0;
  int       holds_done = 0;
  int       hold_left = 0;

  // after reset: lone terminator, header inside a frame, short frame on stale
  // captures, terminator landing on the last position
  stim_row_t dir_rows [27] = '{
    '{8'hFF, 1'b1, '{ActMismatch, 1'b0, 5'd1}},
    '{8'h81, 1'b0, NoRes}, '{8'h01, 1'b0, NoRes}, '{8'h88, 1'b0, NoRes},
    '{8'h01, 1'b0, NoRes}, '{8'h04, 1'b0, NoRes}, '{8'h07, 1'b0, NoRes},
    '{8'h02, 1'b0, NoRes}, '{8'hFF, 1'b1, '{ActZoomTele, 1'b0, 5'd6}},
    '{8'h81, 1'b0, NoRes}, '{8'hFF, 1'b0, NoRes},
    '{8'h88, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'h08, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes}, '{8'h00, 1'b0, NoRes},
    '{8'hFF, 1'b1, '{ActFocusStop, 1'b0, 5'd16}}
  };

  function automatic bit predict_action(input logic [7:0] b, output act_rec_t r);
    logic [4:0] nxt;
    logic [3:0] addr;
    action_e    act;
    if ((b & HdrMask) == HdrMark) frame_pos = '0;
    case (frame_pos)
      5'd0: hdr_cap = b;
      5'd3: cmd_cap = b;
      5'd4: arg_cap = b;
      default: ;
    endcase
    nxt = frame_pos + 5'd1;
    if (b != Terminator && nxt < FrameLen) begin
      frame_pos = nxt;
      r = NoRes;
      return 1'b0;
    end
    addr = hdr_cap[3:0];
    if (addr != dev_addr && addr != BroadcastAddr) begin
      act = ActMismatch;
    end else if (cmd_cap == CmdZoom) begin
      if (arg_cap == ArgUp || arg_cap[7:4] == ZoomTeleHi) act = ActZoomTele;
      else if (arg_cap == ArgDown || arg_cap[7:4] == ZoomWideHi) act = ActZoomWide;
      else if (arg_cap == ArgStop) act = ActZoomStop;
      else act = ActUnknown;
    end else if (cmd_cap == CmdFocus) begin
      if (arg_cap == ArgUp) act = ActFocusFar;
      else if (arg_cap == ArgDown) act = ActFocusNear;
      else if (arg_cap == ArgStop) act = ActFocusStop;
      else act = ActUnknown;
    end else begin
      act = ActUnknown;
    end
    r = '{act, (b != Terminator), nxt};
    frame_pos = '0;
    return 1'b1;
  endfunction

  // starts at a falling edge, returns at the rising edge that took the item
  task automatic send_byte(input logic [7:0] b, input logic typed, input act_rec_t typed_res);
    act_rec_t r;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 18) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
    if (predict_action(b, r)) pending_actions.push_back(typed ? typed_res : r);
  endtask

  task automatic send_frame();
    logic [7:0] fb[$];
    logic [7:0] cmd, arg;
    int         n, shape;
    if ($urandom_range(99) < 75) begin
      case ($urandom_range(2))
        0: fb.push_back({4'h8, dev_addr});
        1: fb.push_back({4'h8, BroadcastAddr});
        default: fb.push_back({4'h8, 4'($urandom)});
      endcase
      fb.push_back(8'h01);
      fb.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(127)) : 8'h04);
      case ($urandom_range(3))
        0: cmd = CmdZoom;
        1: cmd = CmdFocus;
        2: cmd = 8'($urandom);
        default: cmd = 8'($urandom_range(127));
      endcase
      case ($urandom_range(5))
        0: arg = ArgStop;
        1: arg = ArgUp;
        2: arg = ArgDown;
        3: arg = {ZoomTeleHi, 4'($urandom)};
        4: arg = {ZoomWideHi, 4'($urandom)};
        default: arg = 8'($urandom);
      endcase
      fb.push_back(cmd);
      fb.push_back(arg);
      shape = $urandom_range(99);
      if (shape < 65) begin
        fb.push_back(Terminator);
      end else if (shape < 80) begin
        // short frame, decoded on whatever the captures still hold
        n = $urandom_range(1, 4);
        fb = fb[0:n-1];
        fb.push_back(Terminator);
      end else begin
        case ($urandom_range(2))
          0: n = FrameLen - 1;
          1: n = FrameLen;
          default: n = $urandom_range(5, FrameLen - 1);
        endcase
        while (fb.size() < n) fb.push_back(8'($urandom_range(127)));
        if (n < FrameLen) fb.push_back(Terminator);
      end
    end else begin
      n = $urandom_range(1, 20);
      repeat (n) fb.push_back(8'($urandom));
    end
    foreach (fb[i]) send_byte(fb[i], 1'b0, NoRes);
  endtask

  // sender pauses until all items are back, then the address register is written
  task automatic drain_and_config(input logic [3:0] value);
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    dev_addr = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [3:0] plan [5];
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    act_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_ni        = 1'b0;
    frame_pos     = '0;
    hdr_cap       = '0;
    cmd_cap       = '0;
    arg_cap       = '0;
    dev_addr      = DevAddrReset;
    plan = '{4'h0, 4'hF, 4'h8, 4'($urandom), 4'($urandom)};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx_byte, dir_rows[i].typed, dir_rows[i].want);

    for (int phase = 0; phase < 5; phase++) begin
      drain_and_config(plan[phase]);
      @(posedge clk_i);
      calm = (phase == 2);
      if (phase == 1 || phase == 3) holds_asked++;
      n_target: begin
        int target;
        target = bytes_sent + PhaseLen;
        while (bytes_sent < target) send_frame();
      end
    end

    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // output side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left  = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      act_if.ready <= 1'b0;
    end else begin
      act_if.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && act_if.valid && act_if.ready) begin
      if (pending_actions.size() == 0) begin
        $error("item with no expectation: action %0d, overflow %0d, length %0d",
               act_if.action, act_if.ended_by_overflow, act_if.frame_length);
        errors++;
      end else begin
        want = pending_actions.pop_front();
        if (act_if.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, act_if.action);
          errors++;
        end
        if (act_if.ended_by_overflow !== want.ended_by_overflow) begin
          $error("ended_by_overflow: expected %0d, got %0d",
                 want.ended_by_overflow, act_if.ended_by_overflow);
          errors++;
        end
        if (act_if.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d",
                 want.frame_length, act_if.frame_length);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (act_if.valid && act_if.ready)) quiet = 0;
    else quiet++;
    if (quiet >= Watchdog) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

`default_nettype wire
